>>> rtl/slpa_pkg.sv
// Shared types and constants for the SIMT lane PC / priority arbiter.
// No dependencies; used by every module of the block.
`default_nettype none

package slpa_pkg;

   localparam int NUM_WARPS  = 8;
   localparam int LANE_COUNT = 32;
   localparam int PC_BITS    = 32;

   localparam int WARP_IDX_W = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
   localparam int LANE_IDX_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

   // request op codes
   localparam logic [1:0] OP_WRITE_PC   = 2'd0;
   localparam logic [1:0] OP_UPDATE_PRI = 2'd1;
   localparam logic [1:0] OP_ARBITRATE  = 2'd2;

   // priority update kinds (the unused code behaves as lower)
   localparam logic [1:0] PRI_ADD   = 2'd0;
   localparam logic [1:0] PRI_SUB   = 2'd1;
   localparam logic [1:0] PRI_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  warp;
      logic [4:0]  lane;
      logic [31:0] target_pc;
      logic [31:0] lane_mask;
      logic [1:0]  pri_kind;
      logic [7:0]  amount;
      logic [31:0] skip_mask;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [4:0]  chosen_lane;
      logic [31:0] next_pc;
   } rsp_type;

   // running best candidate passed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [LANE_IDX_W-1:0] lane;
      logic [7:0]            pri;
      logic [PC_BITS-1:0]    pc;
   } token_type;

   // write side, common to all cells
   typedef struct packed {
      logic [WARP_IDX_W-1:0] warp_idx;
      logic [PC_BITS-1:0]    pc;
      logic [1:0]            kind;
      logic [7:0]            amount;
   } wr_type;

   // arbitration side, common to all cells
   typedef struct packed {
      logic                  advance;
      logic                  warp_ok;
      logic [WARP_IDX_W-1:0] warp_idx;
   } arb_ctl_type;

endpackage

`default_nettype wire

>>> rtl/slpa_cell.sv
// One lane cell: PC and priority of this lane for every warp, plus one
// stage of the arbitration chain. Depends on slpa_pkg.
`default_nettype none

module slpa_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [slpa_pkg::LANE_IDX_W-1:0] lane_id,
   input  wire slpa_pkg::wr_type                wr,
   input  wire logic                            pc_sel,
   input  wire logic                            pri_sel,
   input  wire slpa_pkg::arb_ctl_type           ctl,
   input  wire logic                            skip,
   input  wire slpa_pkg::token_type             tok_in,
   output slpa_pkg::token_type                  tok_out
);

   logic [slpa_pkg::PC_BITS-1:0] pc_ff  [slpa_pkg::NUM_WARPS];
   logic [7:0]                   pri_ff [slpa_pkg::NUM_WARPS];
   logic [7:0]                   pri_old;
   logic [7:0]                   pri_in;
   logic [7:0]                   rd_pri;
   logic                         take;
   slpa_pkg::token_type          tok_ff;
   slpa_pkg::token_type          tok_pass_in;

   assign pri_old = pri_ff[wr.warp_idx];

   always_comb begin
      unique case (wr.kind)
         slpa_pkg::PRI_CLEAR: pri_in = 8'd0;
         slpa_pkg::PRI_ADD:   pri_in = pri_old + wr.amount;
         default:             pri_in = pri_old - wr.amount;
      endcase
   end

   // compare against the best lane seen so far; ties keep the lower lane
   assign rd_pri = pri_ff[ctl.warp_idx];
   assign take   = ctl.warp_ok && !skip && (!tok_in.found || (rd_pri > tok_in.pri));

   always_comb begin
      tok_pass_in = tok_in;
      if (take) begin
         tok_pass_in.found = 1'b1;
         tok_pass_in.lane  = lane_id;
         tok_pass_in.pri   = rd_pri;
         tok_pass_in.pc    = pc_ff[ctl.warp_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < slpa_pkg::NUM_WARPS; w++) begin
            pc_ff[w]  <= '0;
            pri_ff[w] <= '0;
         end
         tok_ff <= '0;
      end else begin
         if (pc_sel) pc_ff[wr.warp_idx] <= wr.pc;
         if (pri_sel) pri_ff[wr.warp_idx] <= pri_in;
         if (ctl.advance) tok_ff <= tok_pass_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

>>> rtl/simt_lane_pc_priority_arbiter_core.sv
// Top level of the SIMT lane PC / priority arbiter: request decode, the
// row of lane cells and the response register. Depends on slpa_pkg, slpa_cell.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data) carries three ops:
//    write one lane's PC, update the priority of masked lanes, arbitrate a warp.
//  - Writes and priority updates complete at the accepting edge, give no
//    response, and the next request may be accepted in the following cycle.
//  - Arbitrate launches a token that walks the row of lane cells, one lane
//    per cycle while the chain is not frozen, carrying the best (highest
//    priority, lowest lane) candidate. It passes the launch register, then
//    each lane cell in order, then the response register. No new request
//    is taken until the result has reached the response register.
//  - req_ready is low during reset and while an arbitrate is in flight; it
//    rises in the cycle the result lands in the response register.
//  - A pending response may sit while further writes are accepted. If it is
//    still held when the next result reaches the chain end, the chain
//    freezes until the receiver takes it.
//  - Reset (synchronous) zeroes every PC and priority and drops any token.
//  - No lane eligible (all skipped, or warp out of range): all fields zero.
`default_nettype none

module simt_lane_pc_priority_arbiter_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire slpa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output slpa_pkg::rsp_type      rsp_data
);

   localparam int NL = slpa_pkg::LANE_COUNT;

   logic                              accept;
   logic                              warp_ok;
   logic                              lane_ok;
   logic [slpa_pkg::WARP_IDX_W-1:0]   warp_idx;
   logic [NL-1:0]                     pc_sel;
   logic [NL-1:0]                     pri_sel;
   slpa_pkg::wr_type                  wr;
   slpa_pkg::arb_ctl_type             ctl;
   slpa_pkg::token_type               tok [NL+1];

   // in-flight arbitration state
   logic                              busy_ff;
   logic                              launch_ff;
   logic                              arb_ok_ff;
   logic [slpa_pkg::WARP_IDX_W-1:0]   arb_idx_ff;
   logic [NL-1:0]                     arb_skip_ff;
   logic                              advance;
   logic                              rsp_valid_ff;
   slpa_pkg::rsp_type                 rsp_data_ff;

   assign req_ready = !busy_ff && !reset;
   assign accept    = req_valid && req_ready;

   assign warp_ok  = 32'(req_data.warp) < 32'(slpa_pkg::NUM_WARPS);
   assign lane_ok  = 32'(req_data.lane) < 32'(NL);
   assign warp_idx = warp_ok ? slpa_pkg::WARP_IDX_W'(req_data.warp) : '0;

   // per-lane write strobes
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         pc_sel[i]  = accept && (req_data.op == slpa_pkg::OP_WRITE_PC) && warp_ok &&
                      lane_ok && (32'(req_data.lane) == 32'(i));
         pri_sel[i] = accept && (req_data.op == slpa_pkg::OP_UPDATE_PRI) && warp_ok &&
                      req_data.lane_mask[i];
      end
   end

   assign wr.warp_idx = warp_idx;
   assign wr.pc       = slpa_pkg::PC_BITS'(req_data.target_pc);
   assign wr.kind     = req_data.pri_kind;
   assign wr.amount   = req_data.amount;

   // chain freezes only while a finished token waits on a full response slot
   assign advance      = !(tok[NL].valid && rsp_valid_ff && !rsp_ready);
   assign ctl.advance  = advance;
   assign ctl.warp_ok  = arb_ok_ff;
   assign ctl.warp_idx = arb_idx_ff;

   // token entering lane 0: nothing found yet
   always_comb begin
      tok[0]       = '0;
      tok[0].valid = launch_ff;
   end

   for (genvar g = 0; g < NL; g++) begin : g_lane
      slpa_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .lane_id (slpa_pkg::LANE_IDX_W'(g)),
         .wr      (wr),
         .pc_sel  (pc_sel[g]),
         .pri_sel (pri_sel[g]),
         .ctl     (ctl),
         .skip    (arb_skip_ff[g]),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= accept && (req_data.op == slpa_pkg::OP_ARBITRATE);
         if (accept && (req_data.op == slpa_pkg::OP_ARBITRATE)) begin
            busy_ff <= 1'b1;
         end else if (tok[NL].valid && advance) begin
            busy_ff <= 1'b0;
         end
         if (tok[NL].valid && advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload, no reset needed
      if (accept && (req_data.op == slpa_pkg::OP_ARBITRATE)) begin
         arb_ok_ff   <= warp_ok;
         arb_idx_ff  <= warp_idx;
         arb_skip_ff <= req_data.skip_mask[NL-1:0];
      end
      if (tok[NL].valid && advance) begin
         rsp_data_ff.found       <= tok[NL].found;
         rsp_data_ff.chosen_lane <= 5'(tok[NL].lane);
         rsp_data_ff.next_pc     <= 32'(tok[NL].pc);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/slpa_checker.sv
// Port-level checks for simt_lane_pc_priority_arbiter_core, bound to the top.
// Depends on slpa_pkg.
`default_nettype none

module slpa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire slpa_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire slpa_pkg::rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // empty arbitration reports zeros
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.chosen_lane == 5'd0 &&
      rsp_data.next_pc == 32'd0)
      else $error("not-found response carries nonzero lane or pc");

   // an arbitrate blocks further requests until its result is out
   a_arb_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == slpa_pkg::OP_ARBITRATE |=> !req_ready)
      else $error("request accepted while arbitration in flight");

   // a write does not produce a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op != slpa_pkg::OP_ARBITRATE && !rsp_valid
      |=> !rsp_valid)
      else $error("response without arbitrate request");

   // reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind simt_lane_pc_priority_arbiter_core slpa_checker u_slpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/simt_lane_pc_priority_arbiter_core_tb.sv
// Self-checking testbench for simt_lane_pc_priority_arbiter_core: a directed table, then
// random requests, each response checked against a predictor or a typed expected result.
// Depends on slpa_pkg and the core RTL only.

module simt_lane_pc_priority_arbiter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slpa_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] OP_UNUSED  = 2'd3;   // ignored by the block
   localparam logic [1:0] PRI_UNUSED = 2'd3;   // behaves as lower

   localparam int RANDOM_REQUESTS = 1000;
   localparam int DRAIN_EVERY     = 250;
   localparam int SETTLE_CYCLES   = LANE_COUNT + 8;   // arbitrate walk plus margin
   localparam int CYCLE_LIMIT     = 500000;

   localparam logic [31:0] ALL_LANES = 32'hFFFF_FFFF;

   // one line of the directed table; want is used only when typed is set
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor state: one PC and one priority per lane of every warp
   logic [PC_BITS-1:0] pc_table  [NUM_WARPS][LANE_COUNT];
   logic [7:0]         pri_table [NUM_WARPS][LANE_COUNT];

   rsp_type  pending_picks[$];   // expected arbitration results, oldest first
   rsp_type  oldest_pick;
   int       error_count = 0;
   int       cycle_count = 0;
   bit       no_idle = 1'b0;     // long stretch without stalls on either side
   step_type script[];

   simt_lane_pc_priority_arbiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic note_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic req_type cmd(input logic [1:0] op, input logic [2:0] warp,
                                   input logic [4:0] lane, input logic [31:0] pc,
                                   input logic [31:0] lmask, input logic [1:0] kind,
                                   input logic [7:0] amount, input logic [31:0] smask);
      req_type r;
      r.op        = op;
      r.warp      = warp;
      r.lane      = lane;
      r.target_pc = pc;
      r.lane_mask = lmask;
      r.pri_kind  = kind;
      r.amount    = amount;
      r.skip_mask = smask;
      return r;
   endfunction

   // Applies one request to the lane tables. Returns 1 with the expected pick
   // when the request is an arbitrate, which is the only op that responds.
   function automatic bit apply_request(input req_type r, output rsp_type pick);
      bit                 warp_ok;
      bit                 found;
      logic [4:0]         best;
      logic [7:0]         best_pri;
      logic [7:0]         p;
      warp_ok  = int'(r.warp) < NUM_WARPS;
      found    = 1'b0;
      best     = '0;
      best_pri = '0;
      pick     = '0;
      case (r.op)
         OP_WRITE_PC: begin
            if (warp_ok && int'(r.lane) < LANE_COUNT)
               pc_table[r.warp][r.lane] = r.target_pc[PC_BITS-1:0];
            return 1'b0;
         end
         OP_UPDATE_PRI: begin
            if (!warp_ok)
               return 1'b0;
            for (int i = 0; i < LANE_COUNT; i++) begin
               if (r.lane_mask[i]) begin
                  p = pri_table[r.warp][i];
                  if (r.pri_kind == PRI_CLEAR)
                     p = 8'd0;
                  else if (r.pri_kind == PRI_ADD)
                     p = p + r.amount;
                  else
                     p = p - r.amount;     // lower, and the unused kind
                  pri_table[r.warp][i] = p;
               end
            end
            return 1'b0;
         end
         OP_ARBITRATE: begin
            if (warp_ok) begin
               // strictly greater keeps the lowest lane among equal priorities
               for (int i = 0; i < LANE_COUNT; i++) begin
                  if (!r.skip_mask[i] && (!found || pri_table[r.warp][i] > best_pri)) begin
                     found    = 1'b1;
                     best     = 5'(i);
                     best_pri = pri_table[r.warp][i];
                  end
               end
            end
            if (found) begin
               pick.found       = 1'b1;
               pick.chosen_lane = best;
               pick.next_pc     = 32'(pc_table[r.warp][best]);
            end
            return 1'b1;
         end
         default: return 1'b0;   // unused op: no effect
      endcase
   endfunction

   // Presents one request, holds it until accepted, then predicts its effect.
   // Valid is left high so a following request goes out back to back.
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type pick;
      bit      responds;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      responds = apply_request(r, pick);
      if (responds)
         pending_picks.insert(pending_picks.size(), typed ? want : pick);
   endtask

   // Random sender gap, in about one step out of nine.
   task automatic maybe_pause();
      if (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Stops sending until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_picks.size() != 0);
   endtask

   function automatic logic [31:0] random_mask(input bit for_skip);
      int roll;
      roll = $urandom_range(99);
      if (roll < (for_skip ? 30 : 5))
         return 32'd0;
      else if (roll < 40)
         return 32'd1 << $urandom_range(31);
      else if (roll < 47)
         return ALL_LANES;
      else if (roll < 55)
         return ~(32'd1 << $urandom_range(31));   // one lane left (or updated out)
      else if (roll < 75)
         return $urandom & $urandom;              // sparse
      else if (roll < 88)
         return $urandom | $urandom;              // dense
      return $urandom;
   endfunction

   // Random request with noise in the fields its op does not use.
   function automatic req_type random_request();
      req_type r;
      int      roll;
      r    = req_type'({$urandom, $urandom, $urandom, $urandom});
      roll = $urandom_range(99);
      if (roll < 35) begin
         r.op = OP_WRITE_PC;
      end else if (roll < 65) begin
         r.op        = OP_UPDATE_PRI;
         r.lane_mask = random_mask(1'b0);
         r.pri_kind  = 2'($urandom_range(3));
         if ($urandom_range(3) == 0)
            r.amount = 8'($urandom_range(3, 1));   // small steps make near ties
      end else if (roll < 95) begin
         r.op        = OP_ARBITRATE;
         r.skip_mask = random_mask(1'b1);
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   // response side: random back-pressure and in-order checking
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= no_idle || ($urandom_range(99) >= 11);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_picks.size() == 0) begin
            note_error($sformatf("response with none expected: %p", rsp_data));
         end else begin
            oldest_pick = pending_picks.pop_front();
            if (rsp_data.found !== oldest_pick.found)
               note_error($sformatf("found got %b expected %b",
                                    rsp_data.found, oldest_pick.found));
            if (rsp_data.chosen_lane !== oldest_pick.chosen_lane)
               note_error($sformatf("chosen_lane got %0d expected %0d",
                                    rsp_data.chosen_lane, oldest_pick.chosen_lane));
            if (rsp_data.next_pc !== oldest_pick.next_pc)
               note_error($sformatf("next_pc got %h expected %h",
                                    rsp_data.next_pc, oldest_pick.next_pc));
         end
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int sent;
      req_type r;

      for (int w = 0; w < NUM_WARPS; w++)
         for (int l = 0; l < LANE_COUNT; l++) begin
            pc_table[w][l]  = '0;
            pri_table[w][l] = '0;
         end

      // Directed table. Expected results are typed in only where obvious;
      // the rest come from the predictor.
      script = '{
         // after reset every priority is zero: lane 0 wins with PC 0
         '{cmd(OP_ARBITRATE, 3'd0, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b1, '{1'b1, 5'd0, 32'd0}},
         // every lane skipped
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, ALL_LANES),
           1'b1, '{1'b0, 5'd0, 32'd0}},
         '{cmd(OP_WRITE_PC, 3'd0, 5'd0, ALL_LANES, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b0, '0},
         '{cmd(OP_WRITE_PC, 3'd0, 5'd31, 32'h8000_0001, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b0, '0},
         '{cmd(OP_WRITE_PC, 3'd7, 5'd31, 32'hDEAD_BEEF, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b0, '0},
         '{cmd(OP_WRITE_PC, 3'd7, 5'd0, 32'h0000_1234, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b0, '0},
         // all priorities still zero: lane 0 with its all-ones PC
         '{cmd(OP_ARBITRATE, 3'd0, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0),
           1'b1, '{1'b1, 5'd0, ALL_LANES}},
         // top lane raised to the maximum priority
         '{cmd(OP_UPDATE_PRI, 3'd0, 5'd0, 32'd0, 32'h8000_0000, PRI_ADD, 8'd255, 32'd0),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd0, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0), 1'b0, '0},
         // raise wraps 255 back to 0
         '{cmd(OP_UPDATE_PRI, 3'd0, 5'd0, 32'd0, 32'h8000_0000, PRI_ADD, 8'd1, 32'd0),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd0, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0), 1'b0, '0},
         // lower wraps 0 down to 255
         '{cmd(OP_UPDATE_PRI, 3'd7, 5'd0, 32'd0, 32'h0000_0001, PRI_SUB, 8'd1, 32'd0),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0), 1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'h0000_0001),
           1'b0, '0},
         // unused kind acts as lower
         '{cmd(OP_UPDATE_PRI, 3'd7, 5'd0, 32'd0, ALL_LANES, PRI_UNUSED, 8'd2, 32'd0),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0), 1'b0, '0},
         '{cmd(OP_UPDATE_PRI, 3'd7, 5'd0, 32'd0, ALL_LANES, PRI_CLEAR, 8'hAA, 32'd0),
           1'b0, '0},
         // only the end lanes eligible, tie goes low
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'h7FFF_FFFE),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'hFFFF_FFFE),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'h7FFF_FFFF),
           1'b0, '0},
         // unused op with every field loaded: must change nothing
         '{cmd(OP_UNUSED, 3'd7, 5'd31, ALL_LANES, ALL_LANES, PRI_CLEAR, 8'd255, ALL_LANES),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd7, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'h7FFF_FFFF),
           1'b0, '0},
         '{cmd(OP_UPDATE_PRI, 3'd3, 5'd0, 32'd0, 32'h5555_AAAA, PRI_ADD, 8'h80, 32'd0),
           1'b0, '0},
         '{cmd(OP_ARBITRATE, 3'd3, 5'd0, 32'd0, 32'd0, PRI_ADD, 8'd0, 32'd0), 1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_request(script[i].req, script[i].typed, script[i].want);
         maybe_pause();
      end
      drain_results();

      // random part; ignored requests do not count
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         r = random_request();
         send_request(r, 1'b0, '0);
         if (r.op != OP_UNUSED)
            sent++;
         no_idle <= (sent >= 400 && sent < 600);
         if (sent % DRAIN_EVERY == 0 && r.op != OP_UNUSED)
            drain_results();
         maybe_pause();
      end

      req_valid <= 1'b0;
      while (pending_picks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
